@@ sv/calendar_minute_advance_macros.svh @@
// Assertion macros shared by the calendar minute advance RTL.
`ifndef CALENDAR_MINUTE_ADVANCE_MACROS_SVH
`define CALENDAR_MINUTE_ADVANCE_MACROS_SVH

// Checked property, held off while reset is high.
`define CMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds through reset.
`define CMA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/cma_pkg.sv @@
// Types, constants and calendar helpers for the calendar minute advance block.
`timescale 1ns / 1ps

package cma_pkg;

   localparam int ADD_COUNT_MAX_DEF = 4095;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes, paddr[4:2]
   localparam logic [2:0] REG_TARGET_YEAR   = 3'd0;
   localparam logic [2:0] REG_TARGET_MONTH  = 3'd1;
   localparam logic [2:0] REG_TARGET_DAY    = 3'd2;
   localparam logic [2:0] REG_TARGET_HOUR   = 3'd3;
   localparam logic [2:0] REG_TARGET_MINUTE = 3'd4;
   localparam logic [2:0] REG_TARGET_SECOND = 3'd5;

   localparam logic        MODE_LOAD    = 1'b0;
   localparam logic        MODE_ADVANCE = 1'b1;

   localparam logic [5:0]  MINUTE_LAST = 6'd59;
   localparam logic [4:0]  HOUR_LAST   = 5'd23;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [13:0] YEAR_LAST   = 14'd9999;
   localparam logic [6:0]  CENT_LAST   = 7'd99;
   localparam logic [13:0] HUNDRED     = 14'd100;

   localparam logic [13:0] RESET_YEAR    = 14'd2000;
   localparam logic [3:0]  RESET_MONTH   = 4'd1;
   localparam logic [4:0]  RESET_DAY     = 5'd1;
   localparam logic [6:0]  RESET_YEAR_LO = 7'd0;
   localparam logic [7:0]  RESET_YEAR_HI = 8'd20;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } stamp_type;

   typedef struct packed {
      logic        mode;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [4:0]  load_hour;
      logic [5:0]  load_minute;
      logic [5:0]  load_second;
      logic [11:0] minute_count;
   } req_type;

   typedef struct packed {
      logic [13:0] cur_year;
      logic [3:0]  cur_month;
      logic [4:0]  cur_day;
      logic [4:0]  cur_hour;
      logic [5:0]  cur_minute;
      logic [5:0]  cur_second;
      logic        equals_target;
      logic        after_target;
      logic        before_target;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_STEP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Days in a month; every month code outside the 31-day set and February gets 30.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd2:                                        days = leap ? 5'd29 : 5'd28;
         default:                                     days = 5'd30;
      endcase
      return days;
   endfunction

endpackage

@@ sv/cma_csr.sv @@
// APB register file holding the comparison target date and time.
`timescale 1ns / 1ps

module cma_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cma_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cma_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cma_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output cma_pkg::stamp_type                  target
);
   import cma_pkg::*;

   stamp_type  target_ff;
   stamp_type  target_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign target  = target_ff;

   always_comb begin
      target_in = target_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TARGET_YEAR:   target_in.year   = pwdata[13:0];
            REG_TARGET_MONTH:  target_in.month  = pwdata[3:0];
            REG_TARGET_DAY:    target_in.day    = pwdata[4:0];
            REG_TARGET_HOUR:   target_in.hour   = pwdata[4:0];
            REG_TARGET_MINUTE: target_in.minute = pwdata[5:0];
            REG_TARGET_SECOND: target_in.second = pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TARGET_YEAR:   prdata = CSR_DATA_W'(target_ff.year);
         REG_TARGET_MONTH:  prdata = CSR_DATA_W'(target_ff.month);
         REG_TARGET_DAY:    prdata = CSR_DATA_W'(target_ff.day);
         REG_TARGET_HOUR:   prdata = CSR_DATA_W'(target_ff.hour);
         REG_TARGET_MINUTE: prdata = CSR_DATA_W'(target_ff.minute);
         REG_TARGET_SECOND: prdata = CSR_DATA_W'(target_ff.second);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '{year: RESET_YEAR, month: RESET_MONTH, day: RESET_DAY,
                        hour: '0, minute: '0, second: '0};
      end else begin
         target_ff <= target_in;
      end
   end

endmodule

@@ sv/calendar_minute_advance.sv @@
// Calendar minute advance: date and time counter with load, advance and target compare.
//
// Requests arrive on req_valid/req_ready with a req_type payload. A load request
// (mode 0) replaces the stored date and time; an advance request (mode 1) adds
// minute_count minutes, limited to ADD_COUNT_MAX. Each request yields exactly one
// response on rsp_valid/rsp_ready: the stored date and time after the request and
// equal/after/before flags against the target held in the APB registers.
// A load passes from accept through the division state to rsp_valid (a reciprocal
// multiply, then a multiply and subtract, split the year by 100 for the leap-year test); an
// advance steps one minute per cycle through the date step unit, then goes to done.
// With the receiver ready, the next request can be taken in the same cycle that
// rsp_valid rises.
// One request is in flight at a time; req_ready is high only while the sequencer
// is idle, and a new request may enter while the previous response still waits.
// If the receiver stalls, the finished response waits in the sequencer until the
// response register frees up. Reset (synchronous) sets 2000-01-01 00:00:00 and
// the same target, with no response pending.
`timescale 1ns / 1ps
`include "calendar_minute_advance_macros.svh"

module calendar_minute_advance #(
   parameter int ADD_COUNT_MAX = cma_pkg::ADD_COUNT_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cma_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cma_pkg::rsp_type                    rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cma_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cma_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cma_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import cma_pkg::*;

   localparam int CNT_W = $clog2(ADD_COUNT_MAX + 1);
   localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;

   // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
   localparam logic [12:0] DIV100_RECIP = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   stamp_type    target;

   state_type    state_ff, state_in;
   logic [13:0]  year_ff, year_in;
   logic [3:0]   month_ff, month_in;
   logic [4:0]   day_ff, day_in;
   logic [4:0]   hour_ff, hour_in;
   logic [5:0]   minute_ff, minute_in;
   logic [5:0]   second_ff, second_in;
   logic [6:0]   year_lo_ff, year_lo_in;
   logic [7:0]   year_hi_ff, year_hi_in;
   logic         div_phase_ff, div_phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic         req_fire;
   logic [CMP_W-1:0] count_ext;
   logic [CNT_W-1:0] count_lim;
   logic [26:0]  year_prod;
   logic [13:0]  year_cent;
   logic         leap;
   logic [4:0]   mlen;
   logic         min_wrap, hour_wrap, day_wrap, mon_wrap, year_wrap;
   logic [39:0]  cur_flat, tgt_flat;
   logic         done_fire;

   cma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .target  (target)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clamp the requested minute count
   assign count_ext = CMP_W'(req_data.minute_count);
   assign count_lim = (count_ext > CMP_W'(ADD_COUNT_MAX)) ? CNT_W'(ADD_COUNT_MAX)
                                                        : CNT_W'(count_ext);

   assign year_prod = 27'(year_ff) * 27'(DIV100_RECIP);
   assign year_cent = 14'(year_hi_ff) * HUNDRED;

   // Year split as hi*100 + lo: divisible by 400 when lo is 0 and hi by 4
   assign leap = (year_lo_ff == 7'd0) ? (year_hi_ff[1:0] == 2'd0)
                                      : (year_lo_ff[1:0] == 2'd0);
   assign mlen = month_days(month_ff, leap);

   assign min_wrap  = (minute_ff >= MINUTE_LAST);
   assign hour_wrap = (hour_ff >= HOUR_LAST);
   assign day_wrap  = (day_ff >= mlen);
   assign mon_wrap  = (month_ff >= MONTH_LAST);
   assign year_wrap = (year_ff >= YEAR_LAST);

   assign cur_flat  = {year_ff, month_ff, day_ff, hour_ff, minute_ff, second_ff};
   assign tgt_flat  = {target.year, target.month, target.day,
                       target.hour, target.minute, target.second};
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      year_lo_in   = year_lo_ff;
      year_hi_in   = year_hi_ff;
      div_phase_in = div_phase_ff;
      cnt_in       = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.mode == MODE_LOAD) begin
                  year_in      = req_data.load_year;
                  month_in     = req_data.load_month;
                  day_in       = req_data.load_day;
                  hour_in      = req_data.load_hour;
                  minute_in    = req_data.load_minute;
                  second_in    = req_data.load_second;
                  div_phase_in = 1'b0;
                  state_in     = ST_DIV;
               end else begin
                  cnt_in   = count_lim;
                  state_in = ST_STEP;
               end
            end
         end
         ST_DIV: begin
            // hundreds first, then the remainder from them
            if (!div_phase_ff) begin
               year_hi_in   = year_prod[DIV100_SHIFT +: 8];
               div_phase_in = 1'b1;
            end else begin
               year_lo_in = 7'(year_ff - year_cent);
               state_in   = ST_DONE;
            end
         end
         ST_STEP: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in    = cnt_ff - CNT_W'(1);
               minute_in = min_wrap ? 6'd0 : 6'(minute_ff + 6'd1);
               if (min_wrap) begin
                  hour_in = hour_wrap ? 5'd0 : 5'(hour_ff + 5'd1);
                  if (hour_wrap) begin
                     day_in = day_wrap ? 5'd1 : 5'(day_ff + 5'd1);
                     if (day_wrap) begin
                        month_in = mon_wrap ? 4'd1 : 4'(month_ff + 4'd1);
                        if (mon_wrap) begin
                           if (year_wrap) begin
                              year_in    = '0;
                              year_lo_in = '0;
                              year_hi_in = '0;
                           end else begin
                              year_in = 14'(year_ff + 14'd1);
                              if (year_lo_ff == CENT_LAST) begin
                                 year_lo_in = '0;
                                 year_hi_in = 8'(year_hi_ff + 8'd1);
                              end else begin
                                 year_lo_in = 7'(year_lo_ff + 7'd1);
                              end
                           end
                        end
                     end
                  end
               end
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (done_fire) begin
         rsp_data_in.cur_year      = year_ff;
         rsp_data_in.cur_month     = month_ff;
         rsp_data_in.cur_day       = day_ff;
         rsp_data_in.cur_hour      = hour_ff;
         rsp_data_in.cur_minute    = minute_ff;
         rsp_data_in.cur_second    = second_ff;
         rsp_data_in.equals_target = (cur_flat == tgt_flat);
         rsp_data_in.after_target  = (cur_flat > tgt_flat);
         rsp_data_in.before_target = (cur_flat < tgt_flat);
      end
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         year_ff      <= RESET_YEAR;
         month_ff     <= RESET_MONTH;
         day_ff       <= RESET_DAY;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         year_lo_ff   <= RESET_YEAR_LO;
         year_hi_ff   <= RESET_YEAR_HI;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         year_lo_ff   <= year_lo_in;
         year_hi_ff   <= year_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_phase_ff <= div_phase_in;
      cnt_ff       <= cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `CMA_ASSERT(a_flags_onehot, rsp_valid_ff |-> $onehot({rsp_data_ff.equals_target, rsp_data_ff.after_target, rsp_data_ff.before_target}), "compare flags not one-hot")
   `CMA_ASSERT(a_year_split, (state_ff == ST_IDLE) |-> (16'(year_ff) == 16'(16'(year_hi_ff) * 16'd100 + 16'(year_lo_ff))), "year split out of step with year")
   `CMA_ASSERT_ALWAYS(a_lo_range, (state_ff == ST_IDLE) |-> (year_lo_ff <= CENT_LAST), "year remainder out of range")
   `CMA_ASSERT(a_second_hold, (state_ff == ST_STEP) |=> $stable(second_ff), "advance changed the seconds")
   `CMA_ASSERT(a_busy_after_req, req_fire |=> (state_ff != ST_IDLE), "request taken without entering work")

endmodule
